// ===== src/wvmf_pkg.sv =====
package wvmf_pkg;

  localparam int DEF_MAX_COLS = 128;
  localparam int DEF_MAX_ROWS = 128;

  localparam int WIN_SIDE  = 3;
  localparam int WIN_CELLS = 9;

  localparam int COORD_W    = 7;
  localparam int VEC_W      = 7;
  localparam int WEIGHT_W   = 8;
  localparam int SUP_W      = 4;
  localparam int LAT_W      = 8;
  localparam int SCORE_W    = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_LATTICE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LATTICE_HEIGHT = 2'd1;

  localparam logic [LAT_W-1:0] RST_LATTICE_WIDTH  = 8'd80;
  localparam logic [LAT_W-1:0] RST_LATTICE_HEIGHT = 8'd45;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic [WEIGHT_W-1:0]     w;
  } cell_t;

endpackage

// ===== src/wvmf_in_if.sv =====
interface wvmf_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  mode;
  logic [wvmf_pkg::COORD_W-1:0]          row;
  logic [wvmf_pkg::COORD_W-1:0]          col;
  logic signed [wvmf_pkg::VEC_W-1:0]     vec_x;
  logic signed [wvmf_pkg::VEC_W-1:0]     vec_y;
  logic [wvmf_pkg::WEIGHT_W-1:0]         weight;

  modport source (output valid, mode, row, col, vec_x, vec_y, weight, input ready);
  modport sink   (input valid, mode, row, col, vec_x, vec_y, weight, output ready);
endinterface

// ===== src/wvmf_out_if.sv =====
interface wvmf_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [wvmf_pkg::VEC_W-1:0]     out_x;
  logic signed [wvmf_pkg::VEC_W-1:0]     out_y;
  logic                                  filtered;
  logic [wvmf_pkg::SUP_W-1:0]            support;

  modport source (output valid, out_x, out_y, filtered, support, input ready);
  modport sink   (input valid, out_x, out_y, filtered, support, output ready);
endinterface

// ===== src/weighted_vector_median_filter.sv =====
// Weighted 3x3 vector median filter over a lattice of motion vectors held in an
// on-chip memory of MAX_ROWS x MAX_COLS cells. A write beat stores one cell and
// returns an all-zero result. A query beat reads the nine window cells through the
// single memory read port, then, when the centre cell votes and at least three
// cells vote in all, scores each voting candidate against the window with one
// shared multiply-accumulate unit, skipping non-voting candidates. The block
// takes one beat at a time; in_ch.ready is high only while it is idle. Cells
// must be written before they are queried; the memory is not cleared at reset.
module weighted_vector_median_filter #(
  parameter int MAX_COLS = wvmf_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = wvmf_pkg::DEF_MAX_ROWS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [wvmf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wvmf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  wvmf_in_if.sink                            in_ch,
  wvmf_out_if.source                         out_ch
);

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = 4;
  localparam int LAST   = wvmf_pkg::WIN_CELLS - 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CHECK,
    ST_SCORE,
    ST_RESULT
  } state_t;

  state_t state_r;

  logic [wvmf_pkg::LAT_W-1:0] lat_width_r, lat_height_r;
  logic [wvmf_pkg::LAT_W-1:0] w_eff, h_eff;

  wvmf_pkg::cell_t mem [DEPTH];
  wvmf_pkg::cell_t rd_data_r;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic              in_acc, wr_store;

  // query context
  logic [wvmf_pkg::COORD_W-1:0] q_row_r, q_col_r;
  logic                         q_store_r;
  logic [1:0]                   lr_r, lc_r;
  logic [CNT_W-1:0]             iss_cnt_r;
  logic                         cap_vld_r, cap_inb_r, cap_ctr_r;
  logic [8:0]                   ny, nx;
  logic                         issue_inb;
  logic                         voter;

  wvmf_pkg::cell_t              slot_r [wvmf_pkg::WIN_CELLS];
  logic [wvmf_pkg::SUP_W-1:0]   sup_cnt_r;
  logic signed [wvmf_pkg::VEC_W-1:0] ctr_x_r, ctr_y_r;
  logic                         ctr_vote_r;

  // scoring
  wvmf_pkg::cell_t              cand_r;
  logic [CNT_W-1:0]             a_r, t_r;
  logic [wvmf_pkg::SCORE_W-1:0] score_r, best_score_r, score_nxt;
  logic signed [wvmf_pkg::VEC_W-1:0] best_x_r, best_y_r;
  logic                         have_best_r, take_new;
  logic [8:0]                   l1_dist;
  logic [16:0]                  term;

  // result
  logic signed [wvmf_pkg::VEC_W-1:0] out_x_r, out_y_r;
  logic                         out_filt_r;
  logic [wvmf_pkg::SUP_W-1:0]   out_sup_r;

  function automatic logic [7:0] absdiff7(logic signed [6:0] a, logic signed [6:0] b);
    logic signed [7:0] d;
    d = {a[6], a} - {b[6], b};
    return d[7] ? 8'(-d) : 8'(d);
  endfunction

  assign w_eff = (int'(lat_width_r) > MAX_COLS) ? 8'(MAX_COLS) : lat_width_r;
  assign h_eff = (int'(lat_height_r) > MAX_ROWS) ? 8'(MAX_ROWS) : lat_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_width_r  <= wvmf_pkg::RST_LATTICE_WIDTH;
      lat_height_r <= wvmf_pkg::RST_LATTICE_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        wvmf_pkg::REG_LATTICE_WIDTH:  lat_width_r  <= cfg_wdata;
        wvmf_pkg::REG_LATTICE_HEIGHT: lat_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign wr_store    = (int'(in_ch.row) < MAX_ROWS) && (int'(in_ch.col) < MAX_COLS);
  assign wr_addr     = ADDR_W'(int'(in_ch.row) * MAX_COLS + int'(in_ch.col));

  // window position: row + lr - 1, col + lc - 1; bit 8 set means negative
  assign ny        = 9'(q_row_r) + 9'(lr_r) - 9'd1;
  assign nx        = 9'(q_col_r) + 9'(lc_r) - 9'd1;
  assign issue_inb = !ny[8] && (ny[7:0] < h_eff) && !nx[8] && (nx[7:0] < w_eff);
  assign rd_addr   = ADDR_W'(int'(ny[7:0]) * MAX_COLS + int'(nx[7:0]));
  assign voter     = cap_inb_r && (rd_data_r.w != '0);

  always_ff @(posedge clk) begin
    if (in_acc && (in_ch.mode == wvmf_pkg::MODE_WRITE) && wr_store) begin
      mem[wr_addr] <= '{x: in_ch.vec_x, y: in_ch.vec_y, w: in_ch.weight};
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  // shared multiply-accumulate: candidate against the cell at the head of the ring
  assign l1_dist   = 9'(absdiff7(cand_r.x, slot_r[0].x)) + 9'(absdiff7(cand_r.y, slot_r[0].y));
  assign term      = 17'(slot_r[0].w) * 17'(l1_dist);
  assign score_nxt = score_r + wvmf_pkg::SCORE_W'(term);
  assign take_new  = !have_best_r || (score_nxt < best_score_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cap_vld_r <= 1'b0;
    end else begin
      cap_vld_r <= (state_r == ST_LOAD) && (iss_cnt_r < CNT_W'(wvmf_pkg::WIN_CELLS));
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_ch.mode == wvmf_pkg::MODE_WRITE) begin
              out_x_r    <= '0;
              out_y_r    <= '0;
              out_filt_r <= 1'b0;
              out_sup_r  <= '0;
              state_r    <= ST_RESULT;
            end else begin
              q_row_r    <= in_ch.row;
              q_col_r    <= in_ch.col;
              q_store_r  <= wr_store;
              lr_r       <= '0;
              lc_r       <= '0;
              iss_cnt_r  <= '0;
              sup_cnt_r  <= '0;
              ctr_vote_r <= 1'b0;
              state_r    <= ST_LOAD;
            end
          end
        end

        ST_LOAD: begin
          if (iss_cnt_r < CNT_W'(wvmf_pkg::WIN_CELLS)) begin
            cap_inb_r <= issue_inb;
            cap_ctr_r <= (lr_r == 2'd1) && (lc_r == 2'd1);
            iss_cnt_r <= iss_cnt_r + 1'b1;
            if (lc_r == 2'(wvmf_pkg::WIN_SIDE - 1)) begin
              lc_r <= '0;
              lr_r <= lr_r + 1'b1;
            end else begin
              lc_r <= lc_r + 1'b1;
            end
          end else begin
            state_r <= ST_CHECK;
          end
          // shift the arriving cell into the ring; non-voters enter as all zero
          if (cap_vld_r) begin
            for (int i = 0; i < LAST; i++) slot_r[i] <= slot_r[i+1];
            slot_r[LAST] <= voter ? rd_data_r : '0;
            sup_cnt_r <= sup_cnt_r + wvmf_pkg::SUP_W'(voter);
            if (cap_ctr_r) begin
              ctr_x_r    <= rd_data_r.x;
              ctr_y_r    <= rd_data_r.y;
              ctr_vote_r <= voter;
            end
          end
        end

        ST_CHECK: begin
          out_x_r    <= q_store_r ? ctr_x_r : '0;
          out_y_r    <= q_store_r ? ctr_y_r : '0;
          out_filt_r <= 1'b0;
          out_sup_r  <= ctr_vote_r ? sup_cnt_r : '0;
          if (ctr_vote_r && (sup_cnt_r >= wvmf_pkg::SUP_W'(3))) begin
            cand_r      <= slot_r[0];
            a_r         <= '0;
            t_r         <= '0;
            score_r     <= '0;
            have_best_r <= 1'b0;
            state_r     <= ST_SCORE;
          end else begin
            state_r <= ST_RESULT;
          end
        end

        ST_SCORE: begin
          if (cand_r.w == '0) begin
            // skip a non-voting candidate
            for (int i = 0; i < wvmf_pkg::WIN_CELLS; i++)
              slot_r[i] <= slot_r[(i + 1) % wvmf_pkg::WIN_CELLS];
            cand_r <= slot_r[1];
            a_r    <= a_r + 1'b1;
            if (a_r == CNT_W'(LAST)) begin
              out_x_r    <= best_x_r;
              out_y_r    <= best_y_r;
              out_filt_r <= 1'b1;
              state_r    <= ST_RESULT;
            end
          end else if (t_r != CNT_W'(LAST)) begin
            for (int i = 0; i < wvmf_pkg::WIN_CELLS; i++)
              slot_r[i] <= slot_r[(i + 1) % wvmf_pkg::WIN_CELLS];
            score_r <= score_nxt;
            t_r     <= t_r + 1'b1;
          end else begin
            // last term: settle this candidate and step two places to the next one
            if (take_new) begin
              best_score_r <= score_nxt;
              best_x_r     <= cand_r.x;
              best_y_r     <= cand_r.y;
            end
            have_best_r <= 1'b1;
            for (int i = 0; i < wvmf_pkg::WIN_CELLS; i++)
              slot_r[i] <= slot_r[(i + 2) % wvmf_pkg::WIN_CELLS];
            cand_r  <= slot_r[2];
            t_r     <= '0;
            score_r <= '0;
            a_r     <= a_r + 1'b1;
            if (a_r == CNT_W'(LAST)) begin
              out_x_r    <= take_new ? cand_r.x : best_x_r;
              out_y_r    <= take_new ? cand_r.y : best_y_r;
              out_filt_r <= 1'b1;
              state_r    <= ST_RESULT;
            end
          end
        end

        ST_RESULT: begin
          if (out_ch.ready) state_r <= ST_IDLE;
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid    = (state_r == ST_RESULT);
  assign out_ch.out_x    = out_x_r;
  assign out_ch.out_y    = out_y_r;
  assign out_ch.filtered = out_filt_r;
  assign out_ch.support  = out_sup_r;

endmodule

// ===== sim/tb_weighted_vector_median_filter.sv =====
import wvmf_pkg::*;

typedef struct packed {
  logic signed [VEC_W-1:0] x;
  logic signed [VEC_W-1:0] y;
  logic                    filtered;
  logic [SUP_W-1:0]        support;
} median_result_t;

class median_scoreboard;
  logic signed [VEC_W-1:0] mem_x [DEF_MAX_ROWS*DEF_MAX_COLS];
  logic signed [VEC_W-1:0] mem_y [DEF_MAX_ROWS*DEF_MAX_COLS];
  logic [WEIGHT_W-1:0]     mem_w [DEF_MAX_ROWS*DEF_MAX_COLS];
  bit                      written [DEF_MAX_ROWS*DEF_MAX_COLS];
  int unsigned             lat_w = RST_LATTICE_WIDTH;
  int unsigned             lat_h = RST_LATTICE_HEIGHT;
  median_result_t          pending_medians [$];
  int                      errors = 0;

  function void set_register(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_LATTICE_WIDTH: lat_w = val;
      REG_LATTICE_HEIGHT: lat_h = val;
      default: ;
    endcase
  endfunction

  function int outstanding();
    return pending_medians.size();
  endfunction

  // First cell a query of (row, col) would read before it was written, or -1.
  function int first_unwritten(input int row, input int col);
    int unsigned eff_w, eff_h;
    int          nr, nc;
    eff_w = (lat_w < DEF_MAX_COLS) ? lat_w : DEF_MAX_COLS;
    eff_h = (lat_h < DEF_MAX_ROWS) ? lat_h : DEF_MAX_ROWS;
    if (!written[row * DEF_MAX_COLS + col]) return row * DEF_MAX_COLS + col;
    for (nr = row - 1; nr <= row + 1; nr++)
      for (nc = col - 1; nc <= col + 1; nc++)
        if (nr >= 0 && nr < int'(eff_h) && nc >= 0 && nc < int'(eff_w) &&
            !written[nr * DEF_MAX_COLS + nc])
          return nr * DEF_MAX_COLS + nc;
    return -1;
  endfunction

  // Update the lattice copy and queue the filtered vector this beat must produce.
  function void note_beat(input logic mode, input logic [COORD_W-1:0] row, col,
                          input logic signed [VEC_W-1:0] vx, vy,
                          input logic [WEIGHT_W-1:0] wt);
    int unsigned    eff_w, eff_h, cell_idx, n, k, a, b, score, best_score;
    int             dr, dc, nr, nc, dx, dy, best_k;
    int             cand_x [WIN_CELLS];
    int             cand_y [WIN_CELLS];
    int unsigned    cand_w [WIN_CELLS];
    median_result_t res;
    res = '0;
    cell_idx = int'(row) * DEF_MAX_COLS + int'(col);
    if (mode == MODE_WRITE) begin
      mem_x[cell_idx] = vx;
      mem_y[cell_idx] = vy;
      mem_w[cell_idx] = wt;
      written[cell_idx] = 1'b1;
      pending_medians.push_back(res);
      return;
    end
    eff_w = (lat_w < DEF_MAX_COLS) ? lat_w : DEF_MAX_COLS;
    eff_h = (lat_h < DEF_MAX_ROWS) ? lat_h : DEF_MAX_ROWS;
    res.x = mem_x[cell_idx];
    res.y = mem_y[cell_idx];
    if (row < eff_h && col < eff_w && mem_w[cell_idx] != 0) begin
      k = 0;
      for (dr = -1; dr <= 1; dr++) begin
        for (dc = -1; dc <= 1; dc++) begin
          nr = int'(row) + dr;
          nc = int'(col) + dc;
          if (nr >= 0 && nr < int'(eff_h) && nc >= 0 && nc < int'(eff_w)) begin
            n = nr * DEF_MAX_COLS + nc;
            if (mem_w[n] != 0) begin
              cand_x[k] = int'(mem_x[n]);
              cand_y[k] = int'(mem_y[n]);
              cand_w[k] = int'(mem_w[n]);
              k++;
            end
          end
        end
      end
      res.support = SUP_W'(k);
      if (k >= 3) begin
        best_k = 0;
        best_score = 0;
        for (a = 0; a < k; a++) begin
          score = 0;
          for (b = 0; b < k; b++) begin
            dx = cand_x[a] - cand_x[b];
            dy = cand_y[a] - cand_y[b];
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            score += cand_w[b] * (dx + dy);
          end
          // first strict minimum in raster order wins
          if (a == 0 || score < best_score) begin
            best_score = score;
            best_k = int'(a);
          end
        end
        res.x = VEC_W'(cand_x[best_k]);
        res.y = VEC_W'(cand_y[best_k]);
        res.filtered = 1'b1;
      end
    end
    pending_medians.push_back(res);
  endfunction

  function void check_beat(input median_result_t got);
    median_result_t want;
    if (pending_medians.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result beat: x=%0d y=%0d filtered=%0d support=%0d",
                 got.x, got.y, got.filtered, got.support);
      return;
    end
    want = pending_medians.pop_front();
    if (got.x !== want.x || got.y !== want.y || got.filtered !== want.filtered ||
        got.support !== want.support) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected x=%0d y=%0d filtered=%0d support=%0d, got x=%0d y=%0d filtered=%0d support=%0d",
                 want.x, want.y, want.filtered, want.support,
                 got.x, got.y, got.filtered, got.support);
    end
  endfunction
endclass

module tb_weighted_vector_median_filter;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 300;
  localparam int MAX_GAP     = 12;
  localparam int DRAIN_TAIL  = 100;
  localparam int PHASE_BEATS = 44;
  localparam int NUM_PHASES  = 11;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit                    quiet = 1'b0;
  bit                    hold_request = 1'b0;

  median_scoreboard sb = new;

  wvmf_in_if  in_ch ();
  wvmf_out_if out_ch ();

  weighted_vector_median_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #5 clk = ~clk;

  task automatic send_beat(input logic mode, input logic [COORD_W-1:0] row, col,
                           input logic signed [VEC_W-1:0] vx, vy,
                           input logic [WEIGHT_W-1:0] wt);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.mode   <= mode;
    in_ch.row    <= row;
    in_ch.col    <= col;
    in_ch.vec_x  <= vx;
    in_ch.vec_y  <= vy;
    in_ch.weight <= wt;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_beat(mode, row, col, vx, vy, wt);
  endtask

  // Write every cell a query of (r, c) reads that has not been written yet.
  task automatic prepare_query(input int r, input int c);
    int miss;
    miss = sb.first_unwritten(r, c);
    while (miss >= 0) begin
      send_beat(MODE_WRITE, COORD_W'(miss / DEF_MAX_COLS), COORD_W'(miss % DEF_MAX_COLS),
                VEC_W'($urandom), VEC_W'($urandom),
                ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom));
      miss = sb.first_unwritten(r, c);
    end
  endtask

  // Hold the sender until every queued result has been taken.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic set_lattice(input logic [CFG_DATA_W-1:0] w, h);
    logic [CFG_IDX_W-1:0]  spare;
    logic [CFG_DATA_W-1:0] junk;
    spare = ($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B;
    junk = CFG_DATA_W'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LATTICE_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    sb.set_register(REG_LATTICE_WIDTH, w);
    cfg_index <= REG_LATTICE_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    sb.set_register(REG_LATTICE_HEIGHT, h);
    // an index past the register list must leave the lattice alone
    cfg_index <= spare;
    cfg_wdata <= junk;
    @(posedge clk);
    sb.set_register(spare, junk);
    cfg_we <= 1'b0;
  endtask

  function automatic int near_coord(input int centre, input int unsigned limit);
    int v;
    v = centre + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v >= int'(limit)) v = int'(limit) - 1;
    return v;
  endfunction

  task automatic random_beats(input int count, input int phase);
    int unsigned             ew, eh;
    int                      i, pick, anchor_r, anchor_c, base_x, base_y, r, c, miss;
    logic                    md;
    logic signed [VEC_W-1:0] vx, vy;
    logic [WEIGHT_W-1:0]     wt;
    ew = (sb.lat_w < DEF_MAX_COLS) ? sb.lat_w : DEF_MAX_COLS;
    eh = (sb.lat_h < DEF_MAX_ROWS) ? sb.lat_h : DEF_MAX_ROWS;
    anchor_r = (eh == 0) ? 0 : $urandom_range(0, eh - 1);
    anchor_c = (ew == 0) ? 0 : $urandom_range(0, ew - 1);
    base_x = int'($urandom_range(0, 100)) - 50;
    base_y = int'($urandom_range(0, 100)) - 50;
    for (i = 0; i < count; i++) begin
      quiet = (i >= count / 2) && (i < count / 2 + 10);
      if (phase == 0 && i == 5) hold_request = 1'b1;
      if (phase == 2 && i == 20) drain();
      md = ($urandom_range(0, 9) < 4) ? MODE_WRITE : MODE_QUERY;
      pick = $urandom_range(0, 9);
      if (ew == 0 || eh == 0 || pick == 0) begin
        r = $urandom_range(0, DEF_MAX_ROWS - 1);
        c = $urandom_range(0, DEF_MAX_COLS - 1);
      end else if (pick < 6) begin
        // stay around one spot so writes reshape the windows being queried
        r = near_coord(anchor_r, eh);
        c = near_coord(anchor_c, ew);
      end else begin
        r = $urandom_range(0, eh - 1);
        c = $urandom_range(0, ew - 1);
      end
      miss = sb.first_unwritten(r, c);
      if (md == MODE_QUERY && miss >= 0) begin
        // write the cell the query still lacks instead
        md = MODE_WRITE;
        r  = miss / DEF_MAX_COLS;
        c  = miss % DEF_MAX_COLS;
      end
      case ($urandom_range(0, 3))
        0: begin
          vx = VEC_W'($urandom);
          vy = VEC_W'($urandom);
        end
        1: begin
          vx = VEC_W'($urandom_range(0, 1) ? -64 : 63);
          vy = VEC_W'($urandom_range(0, 1) ? -64 : 63);
        end
        default: begin
          // tight cluster gives near-ties between candidates
          vx = VEC_W'(base_x + int'($urandom_range(0, 2)) - 1);
          vy = VEC_W'(base_y + int'($urandom_range(0, 2)) - 1);
        end
      endcase
      pick = $urandom_range(0, 9);
      wt = (pick < 2) ? 8'd0 : (pick == 2) ? 8'd255 : (pick == 3) ? 8'd1 :
           8'($urandom_range(1, 255));
      send_beat(md, COORD_W'(r), COORD_W'(c), vx, vy, wt);
    end
    quiet = 1'b0;
  endtask

  initial begin : result_sink
    int             gap;
    median_result_t got;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        gap = LONG_HOLD;
        hold_request = 1'b0;
      end else begin
        gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.x        = out_ch.out_x;
      got.y        = out_ch.out_y;
      got.filtered = out_ch.filtered;
      got.support  = out_ch.support;
      sb.check_beat(got);
    end
  end

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stalled = 0;
      else stalled++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int          p;
    int unsigned phase_w [NUM_PHASES];
    int unsigned phase_h [NUM_PHASES];
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_LATTICE_WIDTH;
    cfg_wdata    <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.mode   <= MODE_WRITE;
    in_ch.row    <= '0;
    in_ch.col    <= '0;
    in_ch.vec_x  <= '0;
    in_ch.vec_y  <= '0;
    in_ch.weight <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the windows of the directed queries back to back
    quiet = 1'b1;
    prepare_query(0, 0);
    prepare_query(44, 79);
    prepare_query(45, 0);
    prepare_query(0, 80);
    quiet = 1'b0;

    // directed: extremes, lattice edges, ties, thin support, rejected centre
    send_beat(MODE_WRITE, 0, 0, -64, 63, 8'd255);
    send_beat(MODE_WRITE, 127, 127, 63, -64, 8'd1);
    send_beat(MODE_QUERY, 0, 0, 0, 0, 8'd0);
    send_beat(MODE_QUERY, 44, 79, -1, -1, 8'hff);
    send_beat(MODE_QUERY, 45, 0, 0, 0, 8'd0);
    send_beat(MODE_QUERY, 0, 80, 0, 0, 8'd0);
    send_beat(MODE_QUERY, 127, 127, 0, 0, 8'd0);
    send_beat(MODE_WRITE, 39, 39, 4, 0, 8'd5);
    send_beat(MODE_WRITE, 39, 40, 0, 0, 8'd5);
    send_beat(MODE_WRITE, 39, 41, 9, 9, 8'd0);
    send_beat(MODE_WRITE, 40, 39, -9, 9, 8'd0);
    send_beat(MODE_WRITE, 40, 40, 4, 0, 8'd5);
    send_beat(MODE_WRITE, 40, 41, 9, -9, 8'd0);
    send_beat(MODE_WRITE, 41, 39, -9, -9, 8'd0);
    send_beat(MODE_WRITE, 41, 40, 20, 20, 8'd0);
    send_beat(MODE_WRITE, 41, 41, 0, 0, 8'd5);
    send_beat(MODE_QUERY, 40, 40, 0, 0, 8'd0);
    send_beat(MODE_WRITE, 39, 40, 0, 0, 8'd0);
    send_beat(MODE_WRITE, 41, 41, 0, 0, 8'd0);
    send_beat(MODE_QUERY, 40, 40, 0, 0, 8'd0);
    send_beat(MODE_WRITE, 40, 40, -3, 7, 8'd0);
    send_beat(MODE_QUERY, 40, 40, 0, 0, 8'd0);

    phase_w = '{128, 1, 1, 128, 0, 9, 255, 3, 12, 40, 0};
    phase_h = '{128, 1, 128, 1, 7, 0, 200, 3, 10, 30, 0};
    phase_w[NUM_PHASES-1] = $urandom_range(1, 128);
    phase_h[NUM_PHASES-1] = $urandom_range(1, 128);
    for (p = 0; p < NUM_PHASES; p++) begin
      drain();
      set_lattice(CFG_DATA_W'(phase_w[p]), CFG_DATA_W'(phase_h[p]));
      random_beats(PHASE_BEATS, p);
    end

    drain();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
